@@ hw/rtl/silu_activation_unit_macros.svh @@
// assertion macros for the silu activation unit
// used by silu_activation_unit.sv, expects clk and rst_n in scope
`ifndef SILU_ACTIVATION_UNIT_MACROS_SVH
`define SILU_ACTIVATION_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sau_pkg.sv @@
// shared constants and types for the silu activation unit
// no dependencies; imported by silu_activation_unit and the testbench
package sau_pkg;

  typedef enum logic {
    ACT_FORWARD  = 1'b0,
    ACT_BACKWARD = 1'b1
  } action_t;

  // fixed point constants of the sigmoid datapath, all q.30
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [30:0] Q30_HALF  = 31'h2000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  localparam int SIG_LIMIT_INT = 15;
  localparam int TAYLOR_TERMS  = 12;
  // quotient bits of the reciprocal, sp lies in [2^29, 2^30]
  localparam int DIV_STEPS     = 31;

endpackage

@@ hw/rtl/silu_activation_unit.sv @@
// silu activation unit, forward silu(x) and its backward gradient
// depends on sau_pkg and silu_activation_unit_macros.svh
//
// One transaction per cycle goes in while in_ready is high, and one result per
// transaction comes out, in order. The datapath is a fixed pipeline of 80
// register stages plus the output register. The depth comes from exp(-|x|): a
// 12-term series where each term takes a multiply, a reciprocal multiply and a
// correction stage (36 stages), followed by a 31-stage restoring divider for
// 1 / (1 + exp(-|x|)) and eight stages of products, rounding and saturation.
// A stall on the output holds the whole pipeline; one skid register behind
// the output register absorbs the result in flight, so in_ready depends only
// on registered state. There is no state beyond the pipeline and reset only
// clears valid bits.
`include "silu_activation_unit_macros.svh"

module silu_activation_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic signed [DATA_WIDTH-1:0] in_sample,
  input  logic signed [DATA_WIDTH-1:0] in_upstream_grad,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_value
);
  import sau_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int U_W   = FB + 4;
  localparam int CMP_W = ((W > FB + 5) ? W : FB + 5) + 1;
  localparam int PF_W  = W + 32;
  localparam int XQ_W  = W + 30;
  localparam int GD_W  = W + 33;
  localparam int MW    = W + 33;
  localparam int TT    = TAYLOR_TERMS;
  localparam int DS    = DIV_STEPS;

  localparam logic signed [CMP_W-1:0] SIG_LIM = CMP_W'(SIG_LIMIT_INT) << FB;
  localparam logic signed [MW-1:0] SAT_HI = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [MW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [MW-1:0] D_HI   = MW'(33'sh0_8000_0000);
  localparam logic signed [MW-1:0] D_LO   = -D_HI;

  typedef struct packed {
    action_t               act;
    logic                  nonneg;
    logic [4:0]            n;
    logic signed [W-1:0]   x;
    logic signed [W-1:0]   g;
  } side_t;

  // shift right with round to nearest, ties away from zero
  function automatic logic signed [MW-1:0] rnd(input logic signed [MW-1:0] v,
                                               input int unsigned sh);
    logic            neg;
    logic [MW-1:0]   mag;
    logic [MW-1:0]   r;
    neg = v[MW-1];
    mag = neg ? (~v + MW'(1)) : v;
    r   = (mag + (MW'(1) << (sh - 1))) >> sh;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [MW-1:0] v);
    if (v > SAT_HI) return SAT_HI[W-1:0];
    if (v < SAT_LO) return SAT_LO[W-1:0];
    return v[W-1:0];
  endfunction

  logic en;
  logic skid_v_r;
  logic signed [W-1:0] skid_val_r;
  logic out_valid_r;
  logic signed [W-1:0] out_value_r;

  assign en = !skid_v_r;
  assign in_ready = en;

  // stage 0: clamp, magnitude, align to q.24
  logic signed [CMP_W-1:0] xe, xc, xa;
  logic [27:0] s0_u24_nxt;
  side_t s0_side_nxt;
  logic s0_v_r;
  logic [27:0] s0_u24_r;
  side_t s0_side_r;

  always_comb begin
    xe = CMP_W'(in_sample);
    if (xe > SIG_LIM) xc = SIG_LIM;
    else if (xe < -SIG_LIM) xc = -SIG_LIM;
    else xc = xe;
    xa = xc[CMP_W-1] ? -xc : xc;
    s0_u24_nxt = 28'(xa[U_W-1:0]) << (24 - FB);
    s0_side_nxt.act    = action_t'(in_action);
    s0_side_nxt.nonneg = !in_sample[W-1];
    s0_side_nxt.n      = '0;
    s0_side_nxt.x      = in_sample;
    s0_side_nxt.g      = in_upstream_grad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r    <= in_valid;
      s0_u24_r  <= s0_u24_nxt;
      s0_side_r <= s0_side_nxt;
    end
  end

  // stage 1: v = u * log2(e), split into integer and fraction
  logic [58:0] s1_prod;
  side_t s1_side_nxt;
  logic s1_v_r;
  logic [29:0] s1_f_r;
  side_t s1_side_r;

  always_comb begin
    s1_prod = s0_u24_r * LOG2E_Q30;
    s1_side_nxt = s0_side_r;
    s1_side_nxt.n = s1_prod[58:54];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r    <= s0_v_r;
      s1_f_r    <= s1_prod[53:24];
      s1_side_r <= s1_side_nxt;
    end
  end

  // stage 2: w = f * ln2, seeds the series
  logic [59:0] s2_prod;
  logic [30:0]        tk_term_r [0:TT];
  logic signed [32:0] tk_sum_r  [0:TT];
  logic [29:0]        tk_w_r    [0:TT-1];
  side_t              tk_side_r [0:TT];
  logic               tk_v_r    [0:TT];

  assign s2_prod = s1_f_r * LN2_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tk_v_r[0] <= 1'b0;
    end else if (en) begin
      tk_v_r[0]    <= s1_v_r;
      tk_term_r[0] <= Q30_ONE;
      tk_sum_r[0]  <= '0;
      tk_w_r[0]    <= s2_prod[59:30];
      tk_side_r[0] <= s1_side_r;
    end
  end

  // series terms: t_k = ((t_{k-1} * w) >> 30) / k, three stages each
  for (genvar gk = 1; gk <= TT; gk++) begin : g_term
    localparam int K = gk;
    localparam logic [31:0] RecipK = 32'(33'h0_FFFF_FFFF / K);
    localparam logic [3:0] KV = 4'(K);

    logic [60:0] a_mul;
    logic signed [32:0] a_sum_nxt;
    logic a_v_r;
    logic [30:0] a_prod_r;
    logic signed [32:0] a_sum_r;
    side_t a_side_r;

    logic [62:0] b_mul;
    logic b_v_r;
    logic [30:0] b_prod_r;
    logic [30:0] b_qe_r;
    logic signed [32:0] b_sum_r;
    side_t b_side_r;

    logic [30:0] c_rem;
    logic [30:0] c_term_nxt;

    // previous term joins the running sum with alternating sign
    always_comb begin
      a_mul = tk_term_r[gk-1] * tk_w_r[gk-1];
      if (((gk - 1) % 2) == 1) begin
        a_sum_nxt = tk_sum_r[gk-1] - $signed({2'b00, tk_term_r[gk-1]});
      end else begin
        a_sum_nxt = tk_sum_r[gk-1] + $signed({2'b00, tk_term_r[gk-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r <= 1'b0;
      end else if (en) begin
        a_v_r    <= tk_v_r[gk-1];
        a_prod_r <= a_mul[60:30];
        a_sum_r  <= a_sum_nxt;
        a_side_r <= tk_side_r[gk-1];
      end
    end

    // quotient estimate, low by at most one
    assign b_mul = a_prod_r * RecipK;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_v_r <= 1'b0;
      end else if (en) begin
        b_v_r    <= a_v_r;
        b_prod_r <= a_prod_r;
        b_qe_r   <= b_mul[62:32];
        b_sum_r  <= a_sum_r;
        b_side_r <= a_side_r;
      end
    end

    always_comb begin
      c_rem = b_prod_r - 31'(b_qe_r * KV);
      c_term_nxt = (c_rem >= 31'(KV)) ? (b_qe_r + 31'd1) : b_qe_r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tk_v_r[gk] <= 1'b0;
      end else if (en) begin
        tk_v_r[gk]    <= b_v_r;
        tk_term_r[gk] <= c_term_nxt;
        tk_sum_r[gk]  <= b_sum_r;
        tk_side_r[gk] <= b_side_r;
      end
    end

    // w rides along with the term, the last term no longer needs it
    if (gk < TT) begin : g_wpass
      logic [29:0] a_w_r;
      logic [29:0] b_w_r;
      always_ff @(posedge clk) begin
        if (en) begin
          a_w_r      <= tk_w_r[gk-1];
          b_w_r      <= a_w_r;
          tk_w_r[gk] <= b_w_r;
        end
      end
    end
  end

  // last term, then exp(-u) = sum >> n and the divisor 1 + exp(-u)
  logic signed [32:0] f1_sum_nxt;
  logic f1_v_r;
  logic signed [32:0] f1_sum_r;
  side_t f1_side_r;
  logic [30:0] f2_pos;
  logic [30:0] f2_e;

  logic [31:0] dv_d_r   [0:DS-1];
  logic [31:0] dv_rem_r [0:DS-1];
  logic [30:0] dv_q_r   [0:DS];
  side_t       dv_side_r [0:DS];
  logic        dv_v_r   [0:DS];

  always_comb begin
    if ((TT % 2) == 1) begin
      f1_sum_nxt = tk_sum_r[TT] - $signed({2'b00, tk_term_r[TT]});
    end else begin
      f1_sum_nxt = tk_sum_r[TT] + $signed({2'b00, tk_term_r[TT]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r    <= tk_v_r[TT];
      f1_sum_r  <= f1_sum_nxt;
      f1_side_r <= tk_side_r[TT];
    end
  end

  always_comb begin
    f2_pos = f1_sum_r[32] ? '0 : f1_sum_r[30:0];
    f2_e   = f2_pos >> f1_side_r.n;
  end

  // dividend is 2^60 + d/2: top part 2^29, low bits come from d itself
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0]    <= f1_v_r;
      dv_d_r[0]    <= {1'b0, Q30_ONE} + {1'b0, f2_e};
      dv_rem_r[0]  <= {1'b0, Q30_HALF};
      dv_q_r[0]    <= '0;
      dv_side_r[0] <= f1_side_r;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar gi = 1; gi <= DS; gi++) begin : g_div
    logic [32:0] trial;
    logic        ge;

    always_comb begin
      trial = {dv_rem_r[gi-1], dv_d_r[gi-1][DS + 1 - gi]};
      ge    = trial >= {1'b0, dv_d_r[gi-1]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[gi] <= 1'b0;
      end else if (en) begin
        dv_v_r[gi]    <= dv_v_r[gi-1];
        dv_q_r[gi]    <= {dv_q_r[gi-1][29:0], ge};
        dv_side_r[gi] <= dv_side_r[gi-1];
      end
    end

    if (gi < DS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_d_r[gi]   <= dv_d_r[gi-1];
          dv_rem_r[gi] <= ge ? 32'(trial - {1'b0, dv_d_r[gi-1]}) : trial[31:0];
        end
      end
    end
  end

  // p1: sigmoid of the signed sample
  logic p1_v_r;
  logic [30:0] p1_s_r;
  side_t p1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r    <= dv_v_r[DS];
      p1_s_r    <= dv_side_r[DS].nonneg ? dv_q_r[DS] : (Q30_ONE - dv_q_r[DS]);
      p1_side_r <= dv_side_r[DS];
    end
  end

  // p2: x * s for forward, s * (1 - s) for backward
  logic signed [PF_W-1:0] p2_pf_nxt;
  logic [61:0] p2_qp_nxt;
  logic p2_v_r;
  logic signed [PF_W-1:0] p2_pf_r;
  logic [61:0] p2_qp_r;
  logic [30:0] p2_s_r;
  side_t p2_side_r;

  always_comb begin
    p2_pf_nxt = $signed(p1_side_r.x) * $signed({1'b0, p1_s_r});
    p2_qp_nxt = p1_s_r * (Q30_ONE - p1_s_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r    <= p1_v_r;
      p2_pf_r   <= p2_pf_nxt;
      p2_qp_r   <= p2_qp_nxt;
      p2_s_r    <= p1_s_r;
      p2_side_r <= p1_side_r;
    end
  end

  // p3: round both products, forward result is final here
  logic [61:0] p3_qsum;
  logic p3_v_r;
  logic [28:0] p3_q_r;
  logic signed [W-1:0] p3_f_r;
  logic [30:0] p3_s_r;
  side_t p3_side_r;

  assign p3_qsum = p2_qp_r + 62'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r    <= p2_v_r;
      p3_q_r    <= p3_qsum[58:30];
      p3_f_r    <= sat(rnd(MW'(p2_pf_r), 30));
      p3_s_r    <= p2_s_r;
      p3_side_r <= p2_side_r;
    end
  end

  // p4: x * s * (1 - s)
  logic signed [XQ_W-1:0] p4_xq_nxt;
  logic p4_v_r;
  logic signed [XQ_W-1:0] p4_xq_r;
  logic signed [W-1:0] p4_f_r;
  logic [30:0] p4_s_r;
  side_t p4_side_r;

  assign p4_xq_nxt = $signed(p3_side_r.x) * $signed({1'b0, p3_q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else if (en) begin
      p4_v_r    <= p3_v_r;
      p4_xq_r   <= p4_xq_nxt;
      p4_f_r    <= p3_f_r;
      p4_s_r    <= p3_s_r;
      p4_side_r <= p3_side_r;
    end
  end

  // p5: back to q.30
  logic p5_v_r;
  logic signed [XQ_W-1:0] p5_t_r;
  logic signed [W-1:0] p5_f_r;
  logic [30:0] p5_s_r;
  side_t p5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else if (en) begin
      p5_v_r    <= p4_v_r;
      p5_t_r    <= XQ_W'(rnd(MW'(p4_xq_r), FB));
      p5_f_r    <= p4_f_r;
      p5_s_r    <= p4_s_r;
      p5_side_r <= p4_side_r;
    end
  end

  // p6: local derivative, bounded to +-2^31
  logic signed [MW-1:0] p6_dsum;
  logic signed [MW-1:0] p6_dcl;
  logic p6_v_r;
  logic signed [32:0] p6_d_r;
  logic signed [W-1:0] p6_f_r;
  side_t p6_side_r;

  always_comb begin
    p6_dsum = MW'(p5_t_r) + MW'($signed({1'b0, p5_s_r}));
    if (p6_dsum > D_HI) p6_dcl = D_HI;
    else if (p6_dsum < D_LO) p6_dcl = D_LO;
    else p6_dcl = p6_dsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_v_r <= 1'b0;
    end else if (en) begin
      p6_v_r    <= p5_v_r;
      p6_d_r    <= $signed(p6_dcl[32:0]);
      p6_f_r    <= p5_f_r;
      p6_side_r <= p5_side_r;
    end
  end

  // p7: chain rule with the upstream gradient
  logic signed [GD_W-1:0] p7_gd_nxt;
  logic p7_v_r;
  logic signed [GD_W-1:0] p7_gd_r;
  logic signed [W-1:0] p7_f_r;
  action_t p7_act_r;

  assign p7_gd_nxt = $signed(p6_side_r.g) * p6_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_v_r <= 1'b0;
    end else if (en) begin
      p7_v_r   <= p6_v_r;
      p7_gd_r  <= p7_gd_nxt;
      p7_f_r   <= p6_f_r;
      p7_act_r <= p6_side_r.act;
    end
  end

  // p8: pick the result of the requested action
  logic p8_v_r;
  logic signed [W-1:0] p8_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p8_v_r <= 1'b0;
    end else if (en) begin
      p8_v_r   <= p7_v_r;
      p8_val_r <= (p7_act_r == ACT_BACKWARD) ? sat(rnd(MW'(p7_gd_r), 30)) : p7_f_r;
    end
  end

  // output register with one skid entry for the result in flight
  logic push;
  assign push = en && p8_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        out_value_r <= skid_val_r;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= push;
        if (push) begin
          out_value_r <= p8_val_r;
        end
      end
    end else if (push) begin
      skid_v_r   <= 1'b1;
      skid_val_r <= p8_val_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  `SAU_ASSERT_IMP(a_skid_has_out, skid_v_r, out_valid_r, "skid full, output empty")
  `SAU_ASSERT_NXT(a_skid_refills, skid_v_r && out_ready, out_valid_r && !skid_v_r, "skid stuck")
  `SAU_ASSERT_IMP(a_sigmoid_range, dv_v_r[DS], dv_q_r[DS] >= Q30_HALF && dv_q_r[DS] <= Q30_ONE, "bad q")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// testbench for silu_activation_unit: directed table plus random transactions,
// each result checked against its typed value or a fixed point silu/gradient predictor kept here
// depends on sau_pkg and the silu_activation_unit rtl
module testbench;
  import sau_pkg::*;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS = 10;
  localparam int SIG_CLAMP_INT = 15;
  localparam int SERIES_TERMS = 12;
  localparam int RESET_CYCLES = 9;
  localparam int RAND_ITEMS = 1600;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int N_DIRECTED = 24;

  typedef longint unsigned u64_t;

  localparam longint Q30_UNIT = 64'sd1 <<< 30;
  localparam longint DERIV_LIMIT = 64'sd1 <<< 31;
  localparam u64_t LOG2E_FIX = 64'd1549082005;
  localparam u64_t LN2_FIX = 64'd744261118;
  localparam logic [DATA_WIDTH-1:0] OUT_MAX = 16'h7FFF;
  localparam logic [DATA_WIDTH-1:0] OUT_MIN = 16'h8000;

  typedef struct {
    action_t               act;
    logic [DATA_WIDTH-1:0] sample;
    logic [DATA_WIDTH-1:0] grad;
    bit                    typed;
    logic [DATA_WIDTH-1:0] value;
  } silu_row_t;

  typedef struct {
    action_t               act;
    logic [DATA_WIDTH-1:0] sample;
    logic [DATA_WIDTH-1:0] grad;
    logic [DATA_WIDTH-1:0] value;
  } silu_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_action;
  logic signed [DATA_WIDTH-1:0] in_sample;
  logic signed [DATA_WIDTH-1:0] in_upstream_grad;
  logic out_valid;
  logic out_ready;
  logic signed [DATA_WIDTH-1:0] out_value;

  silu_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  // typed values: zero input, saturating extremes, sigmoid(0) = one half
  silu_row_t stimulus_rows [N_DIRECTED] = '{
    '{ACT_FORWARD,  16'h0000, 16'h1234, 1'b1, 16'h0000},
    '{ACT_FORWARD,  16'h7FFF, 16'h0000, 1'b1, 16'h7FFF},
    '{ACT_FORWARD,  16'h8000, 16'hFFFF, 1'b1, 16'h0000},
    '{ACT_BACKWARD, 16'h0000, 16'h0800, 1'b1, 16'h0400},
    '{ACT_BACKWARD, 16'h0000, 16'h8000, 1'b1, 16'hC000},
    '{ACT_BACKWARD, 16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF},
    '{ACT_BACKWARD, 16'h7FFF, 16'h8000, 1'b1, 16'h8000},
    '{ACT_BACKWARD, 16'h099A, 16'h7FFF, 1'b1, 16'h7FFF},
    '{ACT_BACKWARD, 16'h099A, 16'h8000, 1'b1, 16'h8000},
    '{ACT_BACKWARD, 16'h1234, 16'h0000, 1'b1, 16'h0000},
    '{ACT_FORWARD,  16'h0400, 16'h5555, 1'b0, 16'h0000},
    '{ACT_FORWARD,  16'hFC00, 16'hAAAA, 1'b0, 16'h0000},
    '{ACT_FORWARD,  16'h3C00, 16'h0000, 1'b0, 16'h0000},
    '{ACT_FORWARD,  16'h3C01, 16'h0000, 1'b0, 16'h0000},
    '{ACT_FORWARD,  16'hC400, 16'h0000, 1'b0, 16'h0000},
    '{ACT_FORWARD,  16'hC3FF, 16'h0000, 1'b0, 16'h0000},
    '{ACT_BACKWARD, 16'h3C00, 16'h0400, 1'b0, 16'h0000},
    '{ACT_BACKWARD, 16'hC3FF, 16'h0400, 1'b0, 16'h0000},
    '{ACT_BACKWARD, 16'hFAE3, 16'h7FFF, 1'b0, 16'h0000},
    '{ACT_BACKWARD, 16'h8000, 16'h7FFF, 1'b0, 16'h0000},
    '{ACT_FORWARD,  16'h0001, 16'h0000, 1'b0, 16'h0000},
    '{ACT_BACKWARD, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{ACT_BACKWARD, 16'h5555, 16'hAAAA, 1'b0, 16'h0000},
    '{ACT_FORWARD,  16'hAAAA, 16'h5555, 1'b0, 16'h0000}
  };

  silu_activation_unit #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_sample       (in_sample),
    .in_upstream_grad(in_upstream_grad),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shift right with rounding to nearest, ties away from zero
  function automatic longint round_shift(longint v, int sh);
    u64_t mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] clip_to_out(longint v);
    if (v > 32767) return OUT_MAX;
    if (v < -32768) return OUT_MIN;
    return v[DATA_WIDTH-1:0];
  endfunction

  // exp(-u) in q.30 via 2^-n * exp(-frac*ln2), taylor series for the fraction
  function automatic longint exp_neg_fix(u64_t mag_q);
    u64_t scaled;
    u64_t v;
    u64_t f;
    u64_t w;
    u64_t term;
    int n;
    longint acc;
    scaled = mag_q << (24 - FRAC_BITS);
    v = (scaled * LOG2E_FIX) >> 24;
    n = int'(v >> 30);
    f = v & ((64'd1 << 30) - 64'd1);
    w = (f * LN2_FIX) >> 30;
    term = 64'd1 << 30;
    acc = Q30_UNIT;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * w) >> 30) / u64_t'(k);
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    return acc >> n;
  endfunction

  function automatic longint sigmoid_fix(longint x);
    longint lim;
    longint xc;
    u64_t den;
    u64_t sp;
    lim = longint'(SIG_CLAMP_INT) << FRAC_BITS;
    xc = (x > lim) ? lim : ((x < -lim) ? -lim : x);
    den = u64_t'(Q30_UNIT) + u64_t'(exp_neg_fix(u64_t'((xc < 0) ? -xc : xc)));
    sp = ((64'd1 << 60) + den / 64'd2) / den;
    return (xc >= 0) ? longint'(sp) : Q30_UNIT - longint'(sp);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] silu_predict(action_t act,
      logic signed [DATA_WIDTH-1:0] x_raw, logic signed [DATA_WIDTH-1:0] g_raw);
    longint x;
    longint g;
    longint s;
    longint q;
    longint t;
    longint dv;
    x = x_raw;
    g = g_raw;
    s = sigmoid_fix(x);
    if (act == ACT_FORWARD) return clip_to_out(round_shift(x * s, 30));
    q = round_shift(s * (Q30_UNIT - s), 30);
    t = round_shift(x * q, FRAC_BITS);
    dv = s + t;
    if (dv > DERIV_LIMIT) dv = DERIV_LIMIT;
    if (dv < -DERIV_LIMIT) dv = -DERIV_LIMIT;
    return clip_to_out(round_shift(g * dv, 30));
  endfunction

  // entered and left at a falling edge
  task automatic send_item(action_t act, logic [DATA_WIDTH-1:0] x,
      logic [DATA_WIDTH-1:0] g, bit typed, logic [DATA_WIDTH-1:0] typed_val);
    silu_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_sample <= x;
    in_upstream_grad <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r.act = act;
    r.sample = x;
    r.grad = g;
    r.value = typed ? typed_val : silu_predict(act, x, g);
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_random();
    int pick;
    int xv;
    int gv;
    pick = $urandom_range(3);
    case (pick)
      0: xv = $urandom_range(65535);
      1, 2: xv = $urandom_range(16384) - 8192;
      default: begin
        // around the sigmoid clamp at 15.0
        xv = $urandom_range(16384, 14336);
        if ($urandom_range(1)) xv = -xv;
      end
    endcase
    if ($urandom_range(1)) gv = $urandom_range(65535);
    else gv = $urandom_range(8192) - 4096;
    send_item(action_t'($urandom_range(1)), xv[DATA_WIDTH-1:0], gv[DATA_WIDTH-1:0],
              1'b0, '0);
  endtask

  // result side: random stall, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    silu_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result %h with no transaction pending", out_value);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_value !== exp_r.value) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch: action %s sample %h grad %h expected %h got %h",
                     exp_r.act.name(), exp_r.sample, exp_r.grad, exp_r.value, out_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_FORWARD;
    in_sample = '0;
    in_upstream_grad = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stimulus_rows[i])
      send_item(stimulus_rows[i].act, stimulus_rows[i].sample, stimulus_rows[i].grad,
                stimulus_rows[i].typed, stimulus_rows[i].value);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          // sender keeps offering while the result side holds off, so the pipe fills
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_req = 1'b1;
        end
        1: begin
          send_idle_pct = 73;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 73;
        end
        default: begin
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
      endcase
      repeat (RAND_ITEMS / 4) send_random();
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
